// ===== rtl/core/blaq_pkg.sv =====
// Shared types and constants for the binary lifting ancestor query block.
`default_nettype none
package blaq_pkg;

  localparam int NODE_W     = 10;
  localparam int DEP_W      = 10;
  localparam int CNT_W      = 11;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_BUILD = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  // One jump table entry: ancestor index plus an absent mark.
  typedef struct packed {
    logic              absent;
    logic [NODE_W-1:0] idx;
  } jt_entry_t;

  localparam jt_entry_t ENTRY_ABSENT = '{absent: 1'b1, idx: '0};

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAPTURE,
    OP_LOAD_WR,
    OP_B_INIT,
    OP_B_RD1,
    OP_B_RD2,
    OP_B_WR,
    OP_Q_RDDU,
    OP_Q_RDDV,
    OP_Q_SWAP,
    OP_L_RD,
    OP_L_MOVE,
    OP_L_DEP,
    OP_J_INIT,
    OP_J_RDU,
    OP_J_RDV,
    OP_J_CMP,
    OP_F_RD,
    OP_RES_ZERO,
    OP_RES_U,
    OP_RES_F
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   lvl_dec;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    action_t action;
    logic    range_ok;
    logic    lim_zero;
    logic    single_level;
    logic    last_node;
    logic    last_lvl;
    logic    lvl_zero;
    logic    lift_needed;
    logic    rd_present;
    logic    u_eq_v;
  } dp_status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_B_INIT,
    S_B_RD1,
    S_B_RD2,
    S_B_WR,
    S_Q_START,
    S_Q_DV,
    S_Q_SWAP,
    S_L_CHK,
    S_L_MOVE,
    S_L_DEP,
    S_EQ,
    S_J_RDU,
    S_J_RDV,
    S_J_CMP,
    S_F_RD,
    S_F_ANS,
    S_DONE
  } ctl_state_t;

endpackage
`default_nettype wire

// ===== rtl/core/blaq_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module blaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== rtl/core/blaq_dp.sv =====
// Datapath: jump table, depth store, node registers, result and output words.
`default_nettype none
module blaq_dp #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire blaq_pkg::dp_cmd_t                 cmd,
  output blaq_pkg::dp_status_t                   status,
  input  wire logic [blaq_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [1:0]                        in_tuser,
  input  wire logic                              cfg_valid,
  input  wire logic [blaq_pkg::CNT_W-1:0]        cfg_data,
  output logic      [blaq_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic      [0:0]                        out_tuser
);
  import blaq_pkg::*;

  localparam int AW       = $clog2(MAX_NODES);
  localparam int JT_DEPTH = MAX_NODES * LEVELS;
  localparam int JAW      = $clog2(JT_DEPTH);
  localparam int LW       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [16:0]   NODE_LIM = 17'(MAX_NODES);
  localparam logic [LW-1:0] LVL_TOP  = LW'(LEVELS - 1);

  // captured item
  action_t           act_r;
  logic [NODE_W-1:0] node_r;
  logic [NODE_W-1:0] par_r;
  logic              root_r;
  logic [DEP_W-1:0]  dep_in_r;
  logic [NODE_W-1:0] other_r;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  i_inc;
  logic [LW-1:0]     lvl_r;
  logic [LW-1:0]     lvl_m1;
  logic [NODE_W-1:0] u_r;
  logic [NODE_W-1:0] v_r;
  logic [DEP_W-1:0]  du_r;
  logic [DEP_W-1:0]  dv_r;
  logic              hop_ok_r;
  jt_entry_t         pu_r;
  logic [NODE_W-1:0] res_anc_r;
  logic              res_vld_r;
  logic [NODE_W-1:0] out_anc_r;
  logic              out_vld_r;

  // memory ports
  logic             jt_we;
  logic [JAW-1:0]   jt_wa;
  jt_entry_t        jt_wd;
  logic             jt_re;
  logic [JAW-1:0]   jt_ra;
  jt_entry_t        jt_rd;
  logic             dep_we;
  logic [AW-1:0]    dep_wa;
  logic [DEP_W-1:0] dep_wd;
  logic             dep_re;
  logic [AW-1:0]    dep_ra;
  logic [DEP_W-1:0] dep_rd;

  logic node_ok;
  logic other_ok;

  function automatic logic present(jt_entry_t e);
    present = !e.absent && ({7'b0, e.idx} < NODE_LIM);
  endfunction

  function automatic logic [AW-1:0] naddr(logic [NODE_W-1:0] n);
    logic [AW+NODE_W-1:0] w;
    w = {{AW{1'b0}}, n};
    naddr = w[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] caddr(logic [CNT_W-1:0] n);
    logic [AW+CNT_W-1:0] w;
    w = {{AW{1'b0}}, n};
    caddr = w[AW-1:0];
  endfunction

  // level-major layout: level * MAX_NODES + node
  function automatic logic [JAW-1:0] jaddr(logic [LW-1:0] l, logic [AW-1:0] n);
    jaddr = JAW'(l) * JAW'(MAX_NODES) + JAW'(n);
  endfunction

  assign lim      = ({6'b0, count_r} > NODE_LIM) ? NODE_LIM[CNT_W-1:0] : count_r;
  assign i_inc    = i_r + CNT_W'(1);
  assign lvl_m1   = lvl_r - LW'(1);
  assign node_ok  = {7'b0, node_r} < NODE_LIM;
  assign other_ok = {7'b0, other_r} < NODE_LIM;

  always_comb begin
    jt_we  = 1'b0;
    jt_wa  = '0;
    jt_wd  = '0;
    jt_re  = 1'b0;
    jt_ra  = '0;
    dep_we = 1'b0;
    dep_wa = '0;
    dep_wd = '0;
    dep_re = 1'b0;
    dep_ra = '0;
    case (cmd.op)
      OP_LOAD_WR: begin
        jt_we  = node_ok;
        jt_wa  = jaddr('0, naddr(node_r));
        jt_wd  = root_r ? ENTRY_ABSENT : jt_entry_t'{absent: 1'b0, idx: par_r};
        dep_we = node_ok;
        dep_wa = naddr(node_r);
        dep_wd = dep_in_r;
      end
      OP_B_RD1: begin
        jt_re = 1'b1;
        jt_ra = jaddr(lvl_m1, caddr(i_r));
      end
      OP_B_RD2: begin
        jt_re = 1'b1;
        jt_ra = jaddr(lvl_m1, naddr(jt_rd.idx));
      end
      OP_B_WR: begin
        jt_we = 1'b1;
        jt_wa = jaddr(lvl_r, caddr(i_r));
        jt_wd = (hop_ok_r && present(jt_rd)) ? jt_entry_t'{absent: 1'b0, idx: jt_rd.idx}
                                              : ENTRY_ABSENT;
      end
      OP_Q_RDDU: begin
        dep_re = 1'b1;
        dep_ra = naddr(u_r);
      end
      OP_Q_RDDV: begin
        dep_re = 1'b1;
        dep_ra = naddr(v_r);
      end
      OP_L_RD, OP_J_RDU: begin
        jt_re = 1'b1;
        jt_ra = jaddr(lvl_r, naddr(u_r));
      end
      OP_L_MOVE: begin
        dep_re = 1'b1;
        dep_ra = naddr(jt_rd.idx);
      end
      OP_J_RDV: begin
        jt_re = 1'b1;
        jt_ra = jaddr(lvl_r, naddr(v_r));
      end
      OP_F_RD: begin
        jt_re = 1'b1;
        jt_ra = jaddr('0, naddr(u_r));
      end
      default: begin
      end
    endcase
  end

  blaq_ram #(
    .WIDTH ($bits(jt_entry_t)),
    .DEPTH (JT_DEPTH)
  ) u_jt_ram (
    .clk     (clk),
    .wr_en   (jt_we),
    .wr_addr (jt_wa),
    .wr_data (jt_wd),
    .rd_en   (jt_re),
    .rd_addr (jt_ra),
    .rd_data (jt_rd)
  );

  blaq_ram #(
    .WIDTH (DEP_W),
    .DEPTH (MAX_NODES)
  ) u_dep_ram (
    .clk     (clk),
    .wr_en   (dep_we),
    .wr_addr (dep_wa),
    .wr_data (dep_wd),
    .rd_en   (dep_re),
    .rd_addr (dep_ra),
    .rd_data (dep_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(1);
    end else if (cfg_valid) begin
      count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CAPTURE: begin
        act_r     <= action_t'(in_tuser);
        node_r    <= in_tdata[9:0];
        par_r     <= in_tdata[19:10];
        root_r    <= in_tdata[20];
        dep_in_r  <= in_tdata[30:21];
        other_r   <= in_tdata[40:31];
        u_r       <= in_tdata[9:0];
        v_r       <= in_tdata[40:31];
        res_anc_r <= '0;
        res_vld_r <= 1'b0;
      end
      OP_B_INIT: begin
        lvl_r <= LW'(1);
        i_r   <= '0;
      end
      OP_B_RD2: hop_ok_r <= present(jt_rd);
      OP_B_WR: begin
        if (i_inc == lim) begin
          i_r   <= '0;
          lvl_r <= lvl_r + LW'(1);
        end else begin
          i_r <= i_inc;
        end
      end
      OP_Q_RDDV: du_r <= dep_rd;
      OP_Q_SWAP: begin
        // keep the deeper node in u
        if (du_r < dep_rd) begin
          u_r  <= v_r;
          v_r  <= u_r;
          du_r <= dep_rd;
          dv_r <= du_r;
        end else begin
          dv_r <= dep_rd;
        end
        lvl_r <= LVL_TOP;
      end
      OP_L_MOVE: u_r <= jt_rd.idx;
      OP_L_DEP:  du_r <= dep_rd;
      OP_J_INIT: lvl_r <= LVL_TOP;
      OP_J_RDV:  pu_r <= jt_rd;
      OP_J_CMP: begin
        if (present(pu_r) && present(jt_rd) && (pu_r.idx != jt_rd.idx)) begin
          u_r <= pu_r.idx;
          v_r <= jt_rd.idx;
        end
      end
      OP_RES_ZERO: begin
        res_anc_r <= '0;
        res_vld_r <= 1'b1;
      end
      OP_RES_U: begin
        res_anc_r <= u_r;
        res_vld_r <= 1'b1;
      end
      OP_RES_F: begin
        res_anc_r <= present(jt_rd) ? jt_rd.idx : '0;
        res_vld_r <= 1'b1;
      end
      default: begin
      end
    endcase
    if (cmd.lvl_dec) begin
      lvl_r <= lvl_m1;
    end
    if (cmd.out_load) begin
      out_anc_r <= res_anc_r;
      out_vld_r <= res_vld_r;
    end
  end

  always_comb begin
    status.action       = act_r;
    status.range_ok     = node_ok && other_ok;
    status.lim_zero     = (lim == '0);
    status.single_level = (LEVELS == 1);
    status.last_node    = (i_inc == lim);
    status.last_lvl     = (lvl_r == LVL_TOP);
    status.lvl_zero     = (lvl_r == '0);
    status.lift_needed  = {7'b0, du_r} >= ({7'b0, dv_r} + (17'd1 << lvl_r));
    status.rd_present   = present(jt_rd);
    status.u_eq_v       = (u_r == v_r);
  end

  assign out_tdata = {{(OUT_DATA_W-NODE_W){1'b0}}, out_anc_r};
  assign out_tuser = out_vld_r;

endmodule
`default_nettype wire

// ===== rtl/core/blaq_ctl.sv =====
// Controller: sequences load, build and query words over the datapath.
`default_nettype none
module blaq_ctl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  input  wire blaq_pkg::dp_status_t status,
  output blaq_pkg::dp_cmd_t         cmd
);
  import blaq_pkg::*;

  ctl_state_t state_r;
  ctl_state_t state_nxt;
  logic       out_tvalid_r;
  logic       out_tvalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    in_tready      = 1'b0;
    cmd.op         = OP_NOP;
    cmd.lvl_dec    = 1'b0;
    cmd.out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (status.action)
          ACT_LOAD:  state_nxt = S_LOAD;
          ACT_BUILD: state_nxt = S_B_INIT;
          ACT_QUERY: state_nxt = S_Q_START;
          default:   state_nxt = S_DONE;
        endcase
      end
      S_LOAD: begin
        cmd.op    = OP_LOAD_WR;
        state_nxt = S_DONE;
      end
      S_B_INIT: begin
        cmd.op    = OP_B_INIT;
        state_nxt = (status.lim_zero || status.single_level) ? S_DONE : S_B_RD1;
      end
      S_B_RD1: begin
        cmd.op    = OP_B_RD1;
        state_nxt = S_B_RD2;
      end
      S_B_RD2: begin
        cmd.op    = OP_B_RD2;
        state_nxt = S_B_WR;
      end
      S_B_WR: begin
        cmd.op    = OP_B_WR;
        state_nxt = (status.last_node && status.last_lvl) ? S_DONE : S_B_RD1;
      end
      S_Q_START: begin
        if (!status.range_ok) begin
          cmd.op    = OP_RES_ZERO;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_Q_RDDU;
          state_nxt = S_Q_DV;
        end
      end
      S_Q_DV: begin
        cmd.op    = OP_Q_RDDV;
        state_nxt = S_Q_SWAP;
      end
      S_Q_SWAP: begin
        cmd.op    = OP_Q_SWAP;
        state_nxt = S_L_CHK;
      end
      S_L_CHK: begin
        if (status.lift_needed) begin
          cmd.op    = OP_L_RD;
          state_nxt = S_L_MOVE;
        end else if (status.lvl_zero) begin
          state_nxt = S_EQ;
        end else begin
          cmd.lvl_dec = 1'b1;
        end
      end
      S_L_MOVE: begin
        if (status.rd_present) begin
          cmd.op    = OP_L_MOVE;
          state_nxt = S_L_DEP;
        end else if (status.lvl_zero) begin
          state_nxt = S_EQ;
        end else begin
          cmd.lvl_dec = 1'b1;
          state_nxt   = S_L_CHK;
        end
      end
      S_L_DEP: begin
        // depth of the new u is re-read, not derived
        cmd.op = OP_L_DEP;
        if (status.lvl_zero) begin
          state_nxt = S_EQ;
        end else begin
          cmd.lvl_dec = 1'b1;
          state_nxt   = S_L_CHK;
        end
      end
      S_EQ: begin
        if (status.u_eq_v) begin
          cmd.op    = OP_RES_U;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_J_INIT;
          state_nxt = S_J_RDU;
        end
      end
      S_J_RDU: begin
        cmd.op    = OP_J_RDU;
        state_nxt = S_J_RDV;
      end
      S_J_RDV: begin
        cmd.op    = OP_J_RDV;
        state_nxt = S_J_CMP;
      end
      S_J_CMP: begin
        cmd.op = OP_J_CMP;
        if (status.lvl_zero) begin
          state_nxt = S_F_RD;
        end else begin
          cmd.lvl_dec = 1'b1;
          state_nxt   = S_J_RDU;
        end
      end
      S_F_RD: begin
        cmd.op    = OP_F_RD;
        state_nxt = S_F_ANS;
      end
      S_F_ANS: begin
        cmd.op    = OP_RES_F;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_tvalid_r || out_tready) begin
          cmd.out_load   = 1'b1;
          out_tvalid_nxt = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_tvalid_r;

endmodule
`default_nettype wire

// ===== rtl/core/binary_lifting_ancestor_query.sv =====
// Binary lifting LCA block, one word at a time. Build fills the jump table level by level
// over min(node_count, MAX_NODES) nodes through the single jump table read port; a query
// skips the jump phase when the lifted node meets the other. Next word is taken the
// cycle after the result is loaded. Reset (rst_n low, synchronous) clears control and
// sets node_count to 1; table contents are undefined until loaded, no clearing pass.
`default_nettype none
module binary_lifting_ancestor_query #(
  parameter int MAX_NODES = 1024,
  parameter int LEVELS    = 10
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [9:0] node, [19:10] parent_node, [20] is_root, [30:21] node_depth,
  // [40:31] other_node, [47:41] zero
  input  wire logic [47:0] in_tdata,
  // [1:0] action
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [9:0] ancestor, [15:10] zero
  output logic      [15:0] out_tdata,
  // [0] answer_valid
  output logic      [0:0]  out_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [10:0] cfg_data
);
  import blaq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  blaq_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  blaq_dp #(
    .MAX_NODES (MAX_NODES),
    .LEVELS    (LEVELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

// ===== rtl/core/blaq_checker.sv =====
// Port-level checks for the ancestor query block, bound to the top level.
`default_nettype none
module blaq_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [0:0]  out_tuser
);

  // held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word dropped or changed while stalled");

  // acknowledges of load and build carry no ancestor
  a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 16'd0)
    else $error("acknowledge word with non-zero ancestor");

  // one word in flight: no accept right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is being worked");

  // a result cannot follow an accept in the very next cycle unless one was waiting
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result appeared without any work cycles");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind binary_lifting_ancestor_query blaq_checker u_blaq_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the binary lifting ancestor query block.
module tb_top;
  import blaq_pkg::*;

  localparam int NODES       = 1024;
  localparam int LVLS        = 10;
  localparam int QUIET_LIMIT = 200000;
  localparam int SMALL_OPS   = 220;
  localparam int MAX_REPORTS = 10;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]        act;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] parent;
    logic              root;
    logic [DEP_W-1:0]  depth;
    logic [NODE_W-1:0] other;
    bit                hold;   // wait for every answer before sending
  } tree_op_t;

  typedef struct {
    logic [NODE_W-1:0] anc;
    logic              valid;
  } answer_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [1:0]            in_tuser   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic [CNT_W-1:0]      cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_ready;

  // expected-side copy of the tree
  jt_entry_t        lift_tab [NODES][LVLS];
  logic [DEP_W-1:0] depth_tab [NODES];
  int               live_count = 1;

  // tree shape planned for the current round
  int plan_par [NODES];
  bit plan_root [NODES];
  int plan_dep [NODES];
  int order [NODES];

  tree_op_t words_to_send [$];
  answer_t  answers_due [$];
  tree_op_t cur_op;
  bit       in_took = 1'b0;
  int       src_gap = 0;
  int       snk_gap = 0;
  int       idle_pct = 30;
  int       quiet_cycles = 0;
  int       errors = 0;
  int       ops_planned = 0;
  int       ops_done = 0;
  int       queries_done = 0;
  int       builds_done = 0;
  int       answers_checked = 0;
  int       count_writes = 0;

  binary_lifting_ancestor_query DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit hop(input int n, input int lvl, output int to);
    to = int'(lift_tab[n][lvl].idx);
    return !lift_tab[n][lvl].absent;
  endfunction

  function automatic logic [NODE_W-1:0] meet_point(input int a, input int b);
    int u, v, t, pu, pv;
    bit hu, hv;
    u = a;
    v = b;
    if (depth_tab[u] < depth_tab[v]) begin
      t = u;
      u = v;
      v = t;
    end
    // lift the deeper node; a missing jump just leaves it where it is
    for (int i = LVLS - 1; i >= 0; i--)
      if (int'(depth_tab[u]) >= int'(depth_tab[v]) + (1 << i) && hop(u, i, t)) u = t;
    if (u == v) return u[NODE_W-1:0];
    for (int i = LVLS - 1; i >= 0; i--) begin
      hu = hop(u, i, pu);
      hv = hop(v, i, pv);
      if (hu && hv && pu != pv) begin
        u = pu;
        v = pv;
      end
    end
    if (hop(u, 0, t)) return t[NODE_W-1:0];
    return '0;
  endfunction

  function automatic void rebuild_levels();
    int lim, p, q;
    jt_entry_t e;
    lim = (live_count > NODES) ? NODES : live_count;
    for (int j = 1; j < LVLS; j++)
      for (int i = 0; i < lim; i++) begin
        e = ENTRY_ABSENT;
        if (hop(i, j - 1, p) && hop(p, j - 1, q)) begin
          e.absent = 1'b0;
          e.idx    = q[NODE_W-1:0];
        end
        lift_tab[i][j] = e;
      end
  endfunction

  function automatic answer_t tree_answer(input tree_op_t o);
    answer_t r;
    r.anc   = '0;
    r.valid = 1'b0;
    case (o.act)
      ACT_LOAD: begin
        lift_tab[o.node][0].absent = o.root;
        lift_tab[o.node][0].idx    = o.root ? '0 : o.parent;
        depth_tab[o.node]          = o.depth;
      end
      ACT_BUILD: rebuild_levels();
      ACT_QUERY: begin
        r.anc   = meet_point(int'(o.node), int'(o.other));
        r.valid = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic tree_op_t scrambled(input logic [1:0] act);
    tree_op_t o;
    o.act    = act;
    o.node   = NODE_W'($urandom_range(NODES - 1));
    o.parent = NODE_W'($urandom_range(NODES - 1));
    o.root   = 1'($urandom_range(1));
    o.depth  = DEP_W'($urandom_range(NODES - 1));
    o.other  = NODE_W'($urandom_range(NODES - 1));
    o.hold   = 1'b0;
    return o;
  endfunction

  function automatic tree_op_t load_op(input int n, input int p, input bit root, input int d);
    tree_op_t o;
    o       = scrambled(ACT_LOAD);
    o.node  = n[NODE_W-1:0];
    o.root  = root;
    o.depth = d[DEP_W-1:0];
    if (!root) o.parent = p[NODE_W-1:0];
    return o;
  endfunction

  function automatic tree_op_t query_op(input int a, input int b);
    tree_op_t o;
    o       = scrambled(ACT_QUERY);
    o.node  = a[NODE_W-1:0];
    o.other = b[NODE_W-1:0];
    return o;
  endfunction

  task automatic push_op(input tree_op_t o);
    words_to_send.insert(words_to_send.size(), o);
    ops_planned++;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (words_to_send.size() != 0 || in_tvalid || answers_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_node_count(input int value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value[CNT_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    count_writes++;
  endtask

  // random tree over nodes 0..n-1: parents always come earlier in a shuffled order
  task automatic load_tree(input int n, input int chain_pct, input int forest_pct);
    int k, j, t, nd, pa;
    for (k = 0; k < n; k++) order[k] = k;
    for (k = n - 1; k > 0; k--) begin
      j        = $urandom_range(k);
      t        = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (k = 0; k < n; k++) begin
      nd = order[k];
      if (k == 0 || $urandom_range(99) < forest_pct) begin
        plan_root[nd] = 1'b1;
        plan_par[nd]  = nd;
        plan_dep[nd]  = 0;
      end else begin
        pa = ($urandom_range(99) < chain_pct) ? order[k-1] : order[$urandom_range(k - 1)];
        plan_root[nd] = 1'b0;
        plan_par[nd]  = pa;
        plan_dep[nd]  = plan_dep[pa] + 1;
      end
    end
    for (k = 0; k < n; k++) push_op(load_op(k, plan_par[k], plan_root[k], plan_dep[k]));
  endtask

  task automatic add_queries(input int span, input int nq, input int noise_pct);
    int q, a, b, steps, pick;
    tree_op_t o;
    for (q = 0; q < nq; q++) begin
      if ($urandom_range(99) < noise_pct) begin
        // unused code, stray rebuild, or a load that leaves higher levels stale
        pick = $urandom_range(2);
        o = scrambled(pick == 0 ? ACT_UNUSED : (pick == 1 ? ACT_BUILD : ACT_LOAD));
        if (pick == 2) o.parent = NODE_W'($urandom_range(span - 1));
        push_op(o);
      end else begin
        a    = $urandom_range(span - 1);
        pick = $urandom_range(9);
        if (pick == 0) b = a;
        else if (pick < 4) begin
          b     = a;
          steps = $urandom_range(1, 6);
          while (steps > 0 && !plan_root[b]) begin
            b = plan_par[b];
            steps--;
          end
        end else b = $urandom_range(span - 1);
        o      = ($urandom_range(1) == 0) ? query_op(a, b) : query_op(b, a);
        o.hold = (q == 0) && ($urandom_range(3) == 0);
        push_op(o);
      end
    end
  endtask

  // sender: new word only after the previous one was taken
  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_took)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (words_to_send.size() == 0 ||
                   (words_to_send[0].hold && answers_due.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        src_gap = $urandom_range(13);
        in_tvalid <= 1'b0;
      end else begin
        cur_op = words_to_send.pop_front();
        in_tdata  <= {7'b0, cur_op.other, cur_op.depth, cur_op.root,
                      cur_op.parent, cur_op.node};
        in_tuser  <= cur_op.act;
        in_tvalid <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin
    if (snk_gap > 0) begin
      snk_gap--;
      out_tready <= 1'b0;
    end else if (idle_pct != 0 && $urandom_range(99) < 6) begin
      snk_gap = $urandom_range(13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t want;
    if (rst_n) begin
      quiet_cycles++;
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        answers_checked++;
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: unexpected answer word, ancestor %0d valid %0b",
                     $time, out_tdata[NODE_W-1:0], out_tuser[0]);
        end else begin
          want = answers_due.pop_front();
          if (out_tdata !== {{(OUT_DATA_W-NODE_W){1'b0}}, want.anc} ||
              out_tuser[0] !== want.valid) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: answer mismatch, expected ancestor %0d valid %0b, got data %h valid %0b",
                       $time, want.anc, want.valid, out_tdata, out_tuser[0]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        answers_due.insert(answers_due.size(), tree_answer(cur_op));
        quiet_cycles = 0;
        ops_done++;
        if (cur_op.act == ACT_QUERY) queries_done++;
        if (cur_op.act == ACT_BUILD) builds_done++;
      end
      if (cfg_valid && cfg_ready) begin
        live_count   = int'(cfg_data);
        quiet_cycles = 0;
      end
      in_took <= in_tvalid && in_tready;
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    tree_op_t o;
    int n, pick, small_start;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset count of one: single root
    o        = scrambled(ACT_UNUSED);
    o.node   = '1;
    o.parent = '1;
    o.root   = 1'b1;
    o.depth  = '1;
    o.other  = '1;
    push_op(o);
    push_op(load_op(0, 1023, 1, 0));
    push_op(scrambled(ACT_BUILD));
    push_op(query_op(0, 0));

    // two trees: 0-{1,2}, 1-3-4, 2-5 and 6-7
    write_node_count(8);
    push_op(load_op(0, 682, 1, 0));
    push_op(load_op(1, 0, 0, 1));
    push_op(load_op(2, 0, 0, 1));
    push_op(load_op(3, 1, 0, 2));
    push_op(load_op(4, 3, 0, 3));
    push_op(load_op(5, 2, 0, 2));
    push_op(load_op(6, 0, 1, 0));
    push_op(load_op(7, 6, 0, 1));
    push_op(load_op(1023, 0, 0, 1023));   // above the count, never read
    push_op(scrambled(ACT_BUILD));
    o      = query_op(4, 5);
    o.hold = 1'b1;
    push_op(o);
    push_op(query_op(3, 4));
    push_op(query_op(7, 4));   // separate trees: no common ancestor
    push_op(query_op(7, 6));
    push_op(query_op(2, 2));
    push_op(query_op(5, 1));
    push_op(load_op(5, 4, 0, 4));   // reparent without a rebuild
    push_op(query_op(5, 3));
    push_op(load_op(7, 6, 0, 1023));
    push_op(query_op(7, 1));
    o        = scrambled(ACT_UNUSED);
    o.node   = '0;
    o.parent = '0;
    o.root   = 1'b0;
    o.depth  = '0;
    o.other  = '0;
    push_op(o);

    // full table, then an over-range count and a zero count on the same tree
    write_node_count(NODES);
    load_tree(NODES, 85, 0);
    push_op(scrambled(ACT_BUILD));
    push_op(query_op(NODES - 1, 0));
    push_op(query_op(0, NODES - 1));
    add_queries(NODES, 30, 0);
    write_node_count(2047);
    push_op(scrambled(ACT_BUILD));
    add_queries(NODES, 10, 0);
    write_node_count(0);
    push_op(scrambled(ACT_BUILD));
    add_queries(NODES, 10, 0);

    // mostly small trees from here on
    small_start = ops_planned;
    while (ops_planned - small_start < SMALL_OPS) begin
      pick = $urandom_range(9);
      n = (pick == 0) ? 1 : ((pick < 8) ? $urandom_range(2, 40) : $urandom_range(41, 160));
      write_node_count(n);
      if (ops_planned - small_start > SMALL_OPS - 120) idle_pct = 0;
      else idle_pct = ($urandom_range(2) == 0) ? 0 : 30;
      load_tree(n, $urandom_range(90), ($urandom_range(3) == 0) ? 10 : 0);
      push_op(scrambled(ACT_BUILD));
      add_queries(n, $urandom_range(10, 40), 15);
    end

    wait_idle();
    repeat (100) @(posedge clk);
    $display("Sent %0d words (%0d builds, %0d queries) over %0d node counts",
             ops_done, builds_done, queries_done, count_writes);
    $display("Checked %0d answer words, %0d mismatches", answers_checked, errors);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
